>>> hdl/slpg_pkg.sv
// Shared types and constants for the status LED pattern generator.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package slpg_pkg;

    localparam int NOW_W       = 32;
    localparam int TIME_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int PHASE_W     = 2;
    localparam int PAT_W       = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [PAT_W-1:0] {
        PAT_HEARTBEAT = 3'd0,
        PAT_CV        = 3'd1,
        PAT_CC        = 3'd2,
        PAT_KILL      = 3'd3,
        PAT_FAULT     = 3'd4
    } pattern_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FAULT_CHECK_EN  = 3'd0,
        REG_OUTPUT_CHECK_EN = 3'd1,
        REG_CC_HALF_PERIOD  = 3'd2,
        REG_FAULT_HALF      = 3'd3,
        REG_KILL_FLASH      = 3'd4,
        REG_KILL_PAUSE      = 3'd5,
        REG_BEAT_ON         = 3'd6,
        REG_BEAT_OFF        = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic              fault_check_enable;
        logic              output_check_enable;
        logic [TIME_W-1:0] cc_half_period;
        logic [TIME_W-1:0] fault_half_period;
        logic [TIME_W-1:0] kill_flash_time;
        logic [TIME_W-1:0] kill_pause_time;
        logic [TIME_W-1:0] beat_on_time;
        logic [TIME_W-1:0] beat_off_time;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        fault_check_enable:  1'b0,
        output_check_enable: 1'b1,
        cc_half_period:      16'd120,
        fault_half_period:   16'd80,
        kill_flash_time:     16'd80,
        kill_pause_time:     16'd640,
        beat_on_time:        16'd60,
        beat_off_time:       16'd940
    };

    // Declared from the top bit down, so the lowest bits hold now_ms.
    typedef struct packed {
        logic             cc_mode;
        logic             regulator_on;
        logic             pgood_ok;
        logic             kill_asserted;
        logic             fault_active;
        logic [NOW_W-1:0] now_ms;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

    typedef struct packed {
        pattern_t pattern_code;
        logic     led_on;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

>>> hdl/slpg_cfg_regs.sv
// Configuration register file of the status LED pattern generator.
// Depends on slpg_pkg for the register layout and reset values.
`default_nettype none

module slpg_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [slpg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [slpg_pkg::TIME_W-1:0]    cfg_data,
    output slpg_pkg::cfg_t                      cfg
);
    import slpg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_FAULT_CHECK_EN:  cfg_next.fault_check_enable  = cfg_data[0];
                REG_OUTPUT_CHECK_EN: cfg_next.output_check_enable = cfg_data[0];
                REG_CC_HALF_PERIOD:  cfg_next.cc_half_period      = cfg_data;
                REG_FAULT_HALF:      cfg_next.fault_half_period   = cfg_data;
                REG_KILL_FLASH:      cfg_next.kill_flash_time     = cfg_data;
                REG_KILL_PAUSE:      cfg_next.kill_pause_time     = cfg_data;
                REG_BEAT_ON:         cfg_next.beat_on_time        = cfg_data;
                REG_BEAT_OFF:        cfg_next.beat_off_time       = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hdl/slpg_step.sv
// Pattern selection, phase timing and LED decode for one beat, plus the
// pattern and phase state it updates. Depends on slpg_pkg.
`default_nettype none

module slpg_step (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step_en,
    input  wire slpg_pkg::item_t item,
    input  wire slpg_pkg::cfg_t  cfg,
    output slpg_pkg::result_t result
);
    import slpg_pkg::*;

    pattern_t           pattern_reg;
    pattern_t           pattern_next;
    logic [NOW_W-1:0]   start_reg;
    logic [NOW_W-1:0]   start_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;

    logic               changed;
    logic [PHASE_W-1:0] phase_base;
    logic [NOW_W-1:0]   start_base;
    logic [NOW_W-1:0]   elapsed;
    logic [TIME_W-1:0]  limit;
    logic               expired;
    logic               led;

    always_comb
    begin
        if (cfg.fault_check_enable && item.fault_active)
        begin
            pattern_next = PAT_FAULT;
        end
        else if (item.kill_asserted || !item.pgood_ok)
        begin
            pattern_next = PAT_KILL;
        end
        else if (cfg.output_check_enable && item.regulator_on)
        begin
            pattern_next = item.cc_mode ? PAT_CC : PAT_CV;
        end
        else
        begin
            pattern_next = PAT_HEARTBEAT;
        end
    end

    assign changed    = (pattern_next != pattern_reg);
    assign phase_base = changed ? '0 : phase_reg;
    assign start_base = changed ? item.now_ms : start_reg;
    assign elapsed    = item.now_ms - start_base;

    always_comb
    begin
        limit = cfg.beat_on_time;
        led   = 1'b0;
        case (pattern_next)
            PAT_CV:
            begin
                led = 1'b1;
            end
            PAT_CC:
            begin
                limit = cfg.cc_half_period;
            end
            PAT_FAULT:
            begin
                limit = cfg.fault_half_period;
            end
            PAT_KILL:
            begin
                limit = (phase_base == PHASE_W'(3)) ? cfg.kill_pause_time
                                                     : cfg.kill_flash_time;
                led   = (phase_base != PHASE_W'(3)) && (phase_base != PHASE_W'(1));
            end
            default:
            begin
                limit = (phase_base == '0) ? cfg.beat_on_time : cfg.beat_off_time;
                led   = (phase_base == '0);
            end
        endcase
    end

    assign expired = (elapsed >= {{(NOW_W-TIME_W){1'b0}}, limit});

    always_comb
    begin
        phase_next = phase_base;
        start_next = start_base;
        case (pattern_next)
            PAT_CV:
            begin
                phase_next = phase_base;
            end
            PAT_KILL:
            begin
                if (expired)
                begin
                    phase_next = phase_base + PHASE_W'(1);
                    start_next = item.now_ms;
                end
            end
            default:
            begin
                if (expired)
                begin
                    phase_next = phase_base ^ PHASE_W'(1);
                    start_next = item.now_ms;
                end
            end
        endcase
    end

    // The CC and fault patterns show the phase after the toggle.
    always_comb
    begin
        result.pattern_code = pattern_next;
        if (pattern_next == PAT_CC || pattern_next == PAT_FAULT)
        begin
            result.led_on = (phase_next == '0);
        end
        else
        begin
            result.led_on = led;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= PAT_HEARTBEAT;
            start_reg   <= '0;
            phase_reg   <= '0;
        end
        else if (step_en)
        begin
            pattern_reg <= pattern_next;
            start_reg   <= start_next;
            phase_reg   <= phase_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/status_led_pattern_generator_top.sv
// Top level of the status LED pattern generator: input register, step
// logic and result register. Depends on slpg_pkg, slpg_cfg_regs, slpg_step.
//
//   Channel   Direction  Beat contents
//   s_axis    in         one call: timestamp and status flags
//   m_axis    out        one result: LED state and pattern code
//   cfg       in         register write, no handshake
//
// A beat is held in the input register and passes through the step logic
// into the result register once that register is free or its result is
// accepted. One beat is taken per cycle while results are accepted. A
// stalled result holds the step logic; the input register still takes one
// beat while the result waits, then the input stalls. Reset clears the valid
// flags, step state and configuration at once; data registers are not reset.
`default_nettype none

module status_led_pattern_generator_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    // now_ms[31:0], fault_active, kill_asserted, pgood_ok, regulator_on,
    // cc_mode, three zero bits.
    input  wire logic [slpg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // led_on, pattern_code[2:0], four zero bits.
    output      logic [slpg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [slpg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [slpg_pkg::TIME_W-1:0]      cfg_data
);
    import slpg_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result;
    result_t result_reg;
    logic    result_valid_reg;
    logic    advance;

    assign advance       = item_valid_reg && (!result_valid_reg || m_axis_tready);
    assign s_axis_tready = !item_valid_reg || !result_valid_reg || m_axis_tready;

    slpg_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slpg_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                item_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg <= item_t'(s_axis_tdata[ITEM_W-1:0]);
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = result_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, result_reg};

endmodule

`default_nettype wire

>>> hdl/slpg_checker.sv
// Port-level checks for the status LED pattern generator, bound to the top.
// Depends on slpg_pkg and status_led_pattern_generator_top.
`default_nettype none

module slpg_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [slpg_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import slpg_pkg::*;

    logic       in_beat;
    logic       out_beat;
    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        pending_next = pending_reg + 2'(in_beat) - 2'(out_beat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // The input side only stalls when both the input and result registers are full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_beat, 2))
        else $error("result appeared without a beat two cycles earlier");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> (pending_reg != 2'd0) && (pending_reg != 2'd3))
        else $error("result delivered without an outstanding beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[3:1] == PAT_CV) |-> m_axis_tdata[0])
        else $error("steady pattern shown with the LED off");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind status_led_pattern_generator_top slpg_checker u_slpg_checker (.*);

`default_nettype wire
